// ----- hdl/sdi_pkg.sv -----
// Shared types and constants for the SDI-12 command receiver.
// No dependencies; every other file of the block imports this package.
package sdi_pkg;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_BYTE  = 2'd1,
        ACT_BREAK = 2'd2,
        ACT_TICK  = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        ST_BUSY     = 4'd0,
        ST_CHAR     = 4'd1,
        ST_DONE     = 4'd2,
        ST_TIMEOUT  = 4'd3,
        ST_PARITY   = 4'd4,
        ST_ILLEGAL  = 4'd5,
        ST_OVERFLOW = 4'd6,
        ST_RESTART  = 4'd7,
        ST_IGNORED  = 4'd8
    } t_status;

    typedef enum logic {
        RX_IDLE   = 1'b0,
        RX_ACTIVE = 1'b1
    } t_rx_state;

    typedef enum logic {
        CFG_MAX_CHARS  = 1'b0,
        CFG_TIMEOUT_MS = 1'b1
    } t_cfg_index;

    localparam logic [6:0]  CHAR_FIRST_PRINT = 7'd32;
    localparam logic [6:0]  CHAR_CR          = 7'd13;
    localparam logic [6:0]  CHAR_LF          = 7'd10;
    localparam logic [6:0]  CHAR_BANG        = 7'h21;
    localparam logic [15:0] TIMER_MAX        = 16'hFFFF;

    localparam logic [7:0]  MAX_CHARS_RESET  = 8'd79;
    localparam logic [15:0] TIMEOUT_RESET    = 16'd100;

    typedef struct packed {
        logic       parity_err;
        logic       illegal;
        logic       is_bang;
        logic [6:0] char_val;
    } t_byte_chk;

    typedef struct packed {
        t_status    status;
        logic [7:0] char_count;
        logic [7:0] char_index;
        logic [6:0] char_out;
    } t_result;

endpackage

// ----- hdl/sdi12_command_receiver.sv -----
// Top level of the SDI-12 command receiver: stream ports, configuration
// registers and the result register. Depends on sdi_pkg and sdi_rx_fsm.
// Registered output: an accepted event's result is valid in the next cycle.
// Throughput: one event per cycle; each event gives exactly one result.
// The input is stalled only while the result register is full and not taken.
// Synchronous active-low reset clears the state and sets max_chars to 79 and
// timeout_ms to 100.
module sdi12_command_receiver #(
    parameter int BUFFER_SIZE = 80
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [6:0] char_out, [14:7] char_index,
                                        // [22:15] char_count, [23] zero
    output logic [3:0]  m_axis_tuser,   // [3:0] status
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);
    import sdi_pkg::*;

    logic        r_out_valid;
    t_result     r_result;
    t_result     w_result;
    logic        w_fire;
    logic [7:0]  r_max_chars;
    logic [15:0] r_timeout_ms;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_fire        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_chars  <= MAX_CHARS_RESET;
            r_timeout_ms <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_addr))
                CFG_MAX_CHARS:  r_max_chars  <= i_cfg_wdata[7:0];
                CFG_TIMEOUT_MS: r_timeout_ms <= i_cfg_wdata;
                default:        r_max_chars  <= r_max_chars;
            endcase
        end
    end

    sdi_rx_fsm #(
        .BUFFER_SIZE (BUFFER_SIZE)
    ) u_rx_fsm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_fire),
        .i_action     (t_action'(s_axis_tuser)),
        .i_rx_byte    (s_axis_tdata),
        .i_max_chars  (r_max_chars),
        .i_timeout_ms (r_timeout_ms),
        .o_result     (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload register; loaded on every accepted transaction.
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_result <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_result.status;
    assign m_axis_tdata  = {1'b0, r_result.char_count, r_result.char_index,
                            r_result.char_out};

endmodule

// ----- hdl/sdi_byte_check.sv -----
// Classifies one received byte: even parity over eight bits and the legal
// character set (printable, CR, LF). Depends on sdi_pkg.
module sdi_byte_check (
    input  logic [7:0]         i_rx_byte,
    output sdi_pkg::t_byte_chk o_chk
);
    import sdi_pkg::*;

    logic [6:0] w_char;

    assign w_char = i_rx_byte[6:0];

    always_comb begin
        o_chk.parity_err = ^i_rx_byte;
        o_chk.illegal    = (w_char < CHAR_FIRST_PRINT) && (w_char != CHAR_CR)
                           && (w_char != CHAR_LF);
        o_chk.is_bang    = (w_char == CHAR_BANG);
        o_chk.char_val   = w_char;
    end

endmodule

// ----- hdl/sdi_rx_fsm.sv -----
// Reception state (active flag, character count, idle timer) and the
// per-event result logic. Depends on sdi_pkg and sdi_byte_check.
module sdi_rx_fsm #(
    parameter int BUFFER_SIZE = 80
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  sdi_pkg::t_action i_action,
    input  logic [7:0]      i_rx_byte,
    input  logic [7:0]      i_max_chars,
    input  logic [15:0]     i_timeout_ms,
    output sdi_pkg::t_result o_result
);
    import sdi_pkg::*;

    localparam logic [7:0] FULL_MARK = 8'(BUFFER_SIZE - 1);

    t_rx_state  r_state, n_state;
    logic [7:0] r_count, n_count;
    logic [15:0] r_timer, n_timer;

    t_byte_chk  w_chk;
    logic [7:0] w_count_inc;
    logic [15:0] w_timer_inc;

    sdi_byte_check u_byte_check (
        .i_rx_byte (i_rx_byte),
        .o_chk     (w_chk)
    );

    assign w_count_inc = r_count + 8'd1;
    assign w_timer_inc = (r_timer == TIMER_MAX) ? r_timer : r_timer + 16'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RX_IDLE;
            r_count <= '0;
            r_timer <= '0;
        end else if (i_fire) begin
            r_state <= n_state;
            r_count <= n_count;
            r_timer <= n_timer;
        end
    end

    always_comb begin
        n_state             = r_state;
        n_count             = r_count;
        n_timer             = r_timer;
        o_result.status     = ST_BUSY;
        o_result.char_out   = '0;
        o_result.char_index = '0;

        if (i_action == ACT_START) begin
            n_count = '0;
            n_timer = '0;
            if (i_max_chars == 8'd0) begin
                n_state         = RX_IDLE;
                o_result.status = ST_DONE;
            end else begin
                n_state = RX_ACTIVE;
            end
        end else if (r_state == RX_IDLE) begin
            o_result.status = ST_IGNORED;
        end else begin
            unique case (i_action)
                ACT_BREAK: begin
                    n_count         = '0;
                    n_timer         = '0;
                    o_result.status = ST_RESTART;
                end
                ACT_TICK: begin
                    n_timer = w_timer_inc;
                    if ((i_timeout_ms == 16'd0) || (w_timer_inc >= i_timeout_ms)) begin
                        n_state         = RX_IDLE;
                        o_result.status = ST_TIMEOUT;
                    end
                end
                ACT_BYTE: begin
                    // Every byte restarts the idle timer, a rejected one too.
                    n_timer = '0;
                    if (w_chk.parity_err) begin
                        n_state         = RX_IDLE;
                        o_result.status = ST_PARITY;
                    end else if (w_chk.illegal) begin
                        n_state         = RX_IDLE;
                        o_result.status = ST_ILLEGAL;
                    end else begin
                        n_count             = w_count_inc;
                        o_result.char_out   = w_chk.char_val;
                        o_result.char_index = r_count;
                        // Buffer full is checked ahead of the end mark and the limit.
                        if (w_count_inc == FULL_MARK) begin
                            n_state         = RX_IDLE;
                            o_result.status = ST_OVERFLOW;
                        end else if (w_chk.is_bang || (w_count_inc == i_max_chars)) begin
                            n_state         = RX_IDLE;
                            o_result.status = ST_DONE;
                        end else begin
                            o_result.status = ST_CHAR;
                        end
                    end
                end
                default: begin
                    o_result.status = ST_BUSY;
                end
            endcase
        end

        o_result.char_count = n_count;
    end

endmodule

// ----- tb/sdi12_result_checker.sv -----
`timescale 1ns / 1ps
// Result checker for the SDI-12 command receiver: predicts every result from the
// accepted events and register writes, and compares it with the master side.
// Depends on sdi_pkg; instantiated beside the block by tb_sdi12_command_receiver.
module sdi12_result_checker #(
    parameter int BUFFER_SIZE = 80
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,   // [6:0] char_out, [14:7] char_index,
                                        // [22:15] char_count, [23] zero
    input  logic [3:0]  m_axis_tuser,   // [3:0] status
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    output int          o_mismatches,
    output int          o_pending,
    output int          o_checked,
    output int          o_events
);
    import sdi_pkg::*;

    t_rx_state   rx_state;
    logic [7:0]  held;
    logic [15:0] idle_ticks;
    logic [7:0]  limit_chars;
    logic [15:0] limit_ticks;

    t_result     expected_q[$];
    t_result     want;
    t_result     got;
    int          mismatches;
    int          checked;
    int          events;

    // Advances the receiver state by one event and returns the response.
    function automatic t_result receive_event(input t_action act, input logic [7:0] raw);
        t_result     r;
        logic [6:0]  c;
        logic [15:0] t;
        r = '0;
        r.status = ST_BUSY;
        c = raw[6:0];
        if (act == ACT_START) begin
            held = '0;
            idle_ticks = '0;
            if (limit_chars == 8'd0) begin
                rx_state = RX_IDLE;
                r.status = ST_DONE;
            end else begin
                rx_state = RX_ACTIVE;
            end
        end else if (rx_state == RX_IDLE) begin
            r.status = ST_IGNORED;
        end else if (act == ACT_BREAK) begin
            held = '0;
            idle_ticks = '0;
            r.status = ST_RESTART;
        end else if (act == ACT_TICK) begin
            t = (idle_ticks == TIMER_MAX) ? TIMER_MAX : idle_ticks + 16'd1;
            idle_ticks = t;
            if (limit_ticks == 16'd0 || t >= limit_ticks) begin
                rx_state = RX_IDLE;
                r.status = ST_TIMEOUT;
            end
        end else begin
            // Every byte clears the inactivity timer, even one that is rejected.
            idle_ticks = '0;
            if (^raw) begin
                rx_state = RX_IDLE;
                r.status = ST_PARITY;
            end else if (c < CHAR_FIRST_PRINT && c != CHAR_CR && c != CHAR_LF) begin
                rx_state = RX_IDLE;
                r.status = ST_ILLEGAL;
            end else begin
                r.char_out = c;
                r.char_index = held;
                held = held + 8'd1;
                // A full buffer wins over the terminator and the length limit.
                if (held == 8'(BUFFER_SIZE - 1)) begin
                    rx_state = RX_IDLE;
                    r.status = ST_OVERFLOW;
                end else if (c == CHAR_BANG || held == limit_chars) begin
                    rx_state = RX_IDLE;
                    r.status = ST_DONE;
                end else begin
                    r.status = ST_CHAR;
                end
            end
        end
        r.char_count = held;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_state = RX_IDLE;
            held = '0;
            idle_ticks = '0;
            limit_chars = MAX_CHARS_RESET;
            limit_ticks = TIMEOUT_RESET;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_addr))
                    CFG_MAX_CHARS:  limit_chars = i_cfg_wdata[7:0];
                    CFG_TIMEOUT_MS: limit_ticks = i_cfg_wdata;
                endcase
            end
            // The result leaving now belongs to an earlier event, so it is
            // matched before this edge's event is predicted.
            if (m_axis_tvalid && m_axis_tready) begin
                got.status = t_status'(m_axis_tuser);
                got.char_out = m_axis_tdata[6:0];
                got.char_index = m_axis_tdata[14:7];
                got.char_count = m_axis_tdata[22:15];
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with nothing expected: %s %0d %s %0d",
                                 $time, "status", got.status, "char", got.char_out,
                                 "  index %0d count %0d", got.char_index,
                                 got.char_count);
                end else begin
                    want = expected_q.pop_front();
                    checked++;
                    if (got.status !== want.status || got.char_out !== want.char_out ||
                        got.char_index !== want.char_index ||
                        got.char_count !== want.char_count) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: mismatch: expected status %0d char %0d %s",
                                     $time, want.status, want.char_out, "");
                            $display("    expected index %0d count %0d",
                                     want.char_index, want.char_count);
                            $display("    got status %0d char %0d index %0d count %0d",
                                     got.status, got.char_out, got.char_index,
                                     got.char_count);
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                want = receive_event(t_action'(s_axis_tuser), s_axis_tdata);
                expected_q.push_back(want);
                if (want.status != ST_IGNORED)
                    events++;
            end
        end
        o_mismatches <= mismatches;
        o_pending <= expected_q.size();
        o_checked <= checked;
        o_events <= events;
    end

endmodule

// ----- tb/tb_sdi12_command_receiver.sv -----
`timescale 1ns / 1ps
// Testbench top for the SDI-12 command receiver: clock, reset, event stimulus,
// receiver stalls and the verdict. Depends on sdi_pkg and sdi12_result_checker.
module tb_sdi12_command_receiver;
    import sdi_pkg::*;

    localparam int RX_BUFFER_SIZE = 80;
    localparam int TARGET_EVENTS  = 800;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [3:0]  m_axis_tuser;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_addr = 1'b0;
    logic [15:0] i_cfg_wdata = '0;

    int mismatches;
    int pending;
    int checked;
    int events;
    int burst_left;
    int phases;
    int stall_left;
    int cycle_no;
    int sent;

    sdi12_command_receiver #(
        .BUFFER_SIZE(RX_BUFFER_SIZE)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    sdi12_result_checker #(
        .BUFFER_SIZE(RX_BUFFER_SIZE)
    ) result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_events     (events)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #100_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // The receiver starts no new stall while cycle_no[9:8] is zero and stalls
    // more and more often as that field grows.
    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 7) < 2 * cycle_no[9:8]) begin
            m_axis_tready <= 1'b0;
            stall_left <= $urandom_range(0, 6);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] with_parity(input logic [6:0] c);
        return {^c, c};
    endfunction

    function automatic logic [6:0] printable_char();
        logic [6:0] c;
        do
            c = 7'($urandom_range(32, 127));
        while (c == CHAR_BANG);
        return c;
    endfunction

    // Sends one event; the sender works in bursts separated by random gaps.
    task automatic send_event(input t_action act, input logic [7:0] raw);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= raw;
        do
            @(posedge i_clk);
        while (!(s_axis_tvalid && s_axis_tready));
        sent++;
    endtask

    task automatic send_char(input logic [6:0] c);
        send_event(ACT_BYTE, with_parity(c));
    endtask

    // Holds the sender back until every outstanding result has been taken.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do
            @(posedge i_clk);
        while (pending != 0);
    endtask

    task automatic configure(input logic [7:0] max_chars, input logic [15:0] timeout_ms);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= CFG_MAX_CHARS;
        i_cfg_wdata <= {8'd0, max_chars};
        @(posedge i_clk);
        i_cfg_addr <= CFG_TIMEOUT_MS;
        i_cfg_wdata <= timeout_ms;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        phases++;
    endtask

    // One command: a start, a body of mostly valid characters with some
    // ticks, breaks, bad bytes and restarts, an optional terminator, then
    // a few events that usually land on an idle receiver.
    task automatic run_command();
        int len;
        int k;
        int pick;
        logic [6:0] c;
        send_event(ACT_START, rand_byte());
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 90) : $urandom_range(0, 12);
        for (k = 0; k < len; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                send_event(ACT_TICK, rand_byte());
            end else if (pick < 6) begin
                repeat ($urandom_range(2, 12)) send_event(ACT_TICK, rand_byte());
            end else if (pick < 8) begin
                send_event(ACT_BREAK, rand_byte());
            end else if (pick < 10) begin
                c = 7'($urandom);
                send_event(ACT_BYTE, {~^c, c});
            end else if (pick < 12) begin
                do
                    c = 7'($urandom_range(0, 31));
                while (c == CHAR_CR || c == CHAR_LF);
                send_char(c);
            end else if (pick < 13) begin
                send_event(ACT_START, rand_byte());
            end else if (pick < 16) begin
                send_char(pick[0] ? CHAR_CR : CHAR_LF);
            end else begin
                send_char(printable_char());
            end
        end
        if ($urandom_range(0, 2) != 0)
            send_char(CHAR_BANG);
        repeat ($urandom_range(0, 2)) send_event(t_action'($urandom_range(1, 3)), rand_byte());
    endtask

    initial begin
        logic [7:0]  max_sel;
        logic [15:0] timeout_sel;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Events on an idle receiver after reset are ignored.
        send_event(ACT_BYTE, 8'hFF);
        send_event(ACT_BREAK, 8'h00);
        send_event(ACT_TICK, 8'hA5);
        // Normal characters, CR, LF, the top character, a tick, a break and
        // the terminator.
        send_event(ACT_START, 8'h00);
        send_char(7'h61);
        send_char(CHAR_CR);
        send_char(CHAR_LF);
        send_char(7'h7F);
        send_event(ACT_TICK, 8'h5A);
        send_event(ACT_BREAK, 8'hFF);
        send_char(CHAR_FIRST_PRINT);
        send_char(CHAR_BANG);
        // A zero byte has even parity but is a control character.
        send_event(ACT_START, 8'hFF);
        send_event(ACT_BYTE, 8'h00);
        // Parity error.
        send_event(ACT_START, 8'h00);
        send_event(ACT_BYTE, {~^7'h41, 7'h41});
        // A start while a command is in progress begins again from zero.
        send_event(ACT_START, 8'h00);
        send_char(7'h30);
        send_event(ACT_START, 8'h00);
        send_char(7'h31);
        drain();
        // Zero length limit finishes at once; zero timeout expires on the first tick.
        configure(8'd0, 16'd0);
        send_event(ACT_START, 8'h00);
        send_event(ACT_TICK, 8'h00);
        drain();
        configure(8'd255, 16'd0);
        send_event(ACT_START, 8'h00);
        send_event(ACT_TICK, 8'h00);
        drain();
        configure(8'd1, 16'hFFFF);
        send_event(ACT_START, 8'h00);
        send_char(7'h7A);
        drain();

        while (sent < TARGET_EVENTS) begin
            case ($urandom_range(0, 7))
                0:       max_sel = 8'd0;
                1:       max_sel = 8'd255;
                2:       max_sel = 8'd1;
                3:       max_sel = 8'($urandom_range(78, 80));
                default: max_sel = 8'($urandom_range(2, 20));
            endcase
            case ($urandom_range(0, 5))
                0:       timeout_sel = 16'd0;
                1:       timeout_sel = 16'hFFFF;
                2:       timeout_sel = 16'd1;
                default: timeout_sel = 16'($urandom_range(2, 40));
            endcase
            configure(max_sel, timeout_sel);
            repeat ($urandom_range(1, 6)) run_command();
            drain();
        end
        repeat (4) @(posedge i_clk);

        $display("Checked %0d results over %0d register settings.", checked, phases);
        $display("%0d of %0d events reached an armed receiver or started one.",
                 events, sent);
        if (mismatches == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
